/* hdl/smdt_pkg.sv */
// ----------------------------------------------------------------------------
// smdt_pkg: shared types, constants and tables
// Month codes, the non-leap month table, month name letters and the
// reciprocal constants used for the divide-by-constant steps.
// ----------------------------------------------------------------------------
package smdt_pkg;

  // ASCII code of the digit zero
  localparam logic [5:0] AsciiZero = 6'd48;

  // Days in a non-leap year, used for the single wrap of day of year
  localparam logic [9:0] DaysPerYear = 10'd365;

  // x / 15 = (x * Recip15Wide) >> Recip15WideShift, exact for x < 2^24
  localparam logic [24:0] Recip15Wide      = 25'd17895698;
  localparam int unsigned Recip15WideShift = 28;
  // x / 15 = (x * Recip15Narrow) >> Recip15NarrowShift, exact for x < 2^19
  localparam logic [20:0] Recip15Narrow      = 21'd1118482;
  localparam int unsigned Recip15NarrowShift = 24;
  // x / 3 = (x * Recip3) >> Recip3Shift, exact for x < 2^12
  localparam logic [12:0] Recip3      = 13'd5462;
  localparam int unsigned Recip3Shift = 14;

  // Month codes; MonNone marks a day of year past the end of the table
  typedef enum logic [3:0] {
    MonJan  = 4'd0,
    MonFeb  = 4'd1,
    MonMar  = 4'd2,
    MonApr  = 4'd3,
    MonMay  = 4'd4,
    MonJun  = 4'd5,
    MonJul  = 4'd6,
    MonAug  = 4'd7,
    MonSep  = 4'd8,
    MonOct  = 4'd9,
    MonNov  = 4'd10,
    MonDec  = 4'd11,
    MonNone = 4'd12
  } month_e;

  localparam int unsigned MonthCount = 12;

  // Calendar result: three month letters (first letter in the top bits)
  // and the day of month
  typedef struct packed {
    logic [20:0] letters;
    logic [5:0]  dom;
  } cal_t;

  // Days before each month; MonNone gives the days of the whole year
  function automatic logic [8:0] days_before(input month_e mon);
    logic [8:0] days;
    unique case (mon)
      MonJan:  days = 9'd0;
      MonFeb:  days = 9'd31;
      MonMar:  days = 9'd59;
      MonApr:  days = 9'd90;
      MonMay:  days = 9'd120;
      MonJun:  days = 9'd151;
      MonJul:  days = 9'd181;
      MonAug:  days = 9'd212;
      MonSep:  days = 9'd243;
      MonOct:  days = 9'd273;
      MonNov:  days = 9'd304;
      MonDec:  days = 9'd334;
      MonNone: days = 9'd365;
      default: days = 9'd0;
    endcase
    return days;
  endfunction

  // Upper-case three-letter month name; all zero when no month matched
  function automatic logic [20:0] month_letters(input month_e mon);
    logic [20:0] name;
    unique case (mon)
      MonJan:  name = {7'("J"), 7'("A"), 7'("N")};
      MonFeb:  name = {7'("F"), 7'("E"), 7'("B")};
      MonMar:  name = {7'("M"), 7'("A"), 7'("R")};
      MonApr:  name = {7'("A"), 7'("P"), 7'("R")};
      MonMay:  name = {7'("M"), 7'("A"), 7'("Y")};
      MonJun:  name = {7'("J"), 7'("U"), 7'("N")};
      MonJul:  name = {7'("J"), 7'("U"), 7'("L")};
      MonAug:  name = {7'("A"), 7'("U"), 7'("G")};
      MonSep:  name = {7'("S"), 7'("E"), 7'("P")};
      MonOct:  name = {7'("O"), 7'("C"), 7'("T")};
      MonNov:  name = {7'("N"), 7'("O"), 7'("V")};
      MonDec:  name = {7'("D"), 7'("E"), 7'("C")};
      MonNone: name = 21'd0;
      default: name = 21'd0;
    endcase
    return name;
  endfunction

endpackage

/* hdl/smdt_pipe_reg.sv */
// ----------------------------------------------------------------------------
// smdt_pipe_reg: one pipeline stage register with valid and stall
// Holds one transaction; takes a new one whenever it is empty or its
// contents move on in the same cycle.
// ----------------------------------------------------------------------------
module smdt_pipe_reg #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  output logic             stall_o,
  input  logic [Width-1:0] data_i,
  output logic             valid_o,
  input  logic             stall_i,
  output logic [Width-1:0] data_o
);

  logic             valid_d, valid_q;
  logic [Width-1:0] data_d, data_q;

  // stall upstream only while holding a transaction that cannot leave
  assign stall_o = valid_q & stall_i;

  assign valid_d = stall_o ? valid_q : valid_i;
  assign data_d  = (!stall_o && valid_i) ? data_i : data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  // payload: no reset
  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

/* hdl/smdt_calendar.sv */
// ----------------------------------------------------------------------------
// smdt_calendar: day of year to month name and day of month
// Matches the day of year against the non-leap month table. Past the end
// of the table the letters are zero and the day is counted from day 365.
// ----------------------------------------------------------------------------
module smdt_calendar (
  input  logic [8:0]     doy_i,
  output smdt_pkg::cal_t cal_o
);

  smdt_pkg::month_e mon;
  logic [8:0]       dom_wide;

  // first month whose last day is not below the day of year
  always_comb begin
    mon = smdt_pkg::MonNone;
    for (int m = smdt_pkg::MonthCount - 1; m >= 0; m--) begin
      if (doy_i <= smdt_pkg::days_before(smdt_pkg::month_e'(4'(m + 1)))) begin
        mon = smdt_pkg::month_e'(4'(m));
      end
    end
  end

  // day of month; at most 47 even when no month matched
  assign dom_wide      = doy_i - smdt_pkg::days_before(mon);
  assign cal_o.dom     = dom_wide[5:0];
  assign cal_o.letters = smdt_pkg::month_letters(mon);

endmodule

/* hdl/smdt_ascii_digits.sv */
// ----------------------------------------------------------------------------
// smdt_ascii_digits: two-digit ASCII split of a small value
// Value is below 64, so the tens digit comes from a short compare chain.
// ----------------------------------------------------------------------------
module smdt_ascii_digits (
  input  logic [5:0] value_i,
  output logic [5:0] tens_o,
  output logic [5:0] ones_o
);

  logic [2:0] tens;
  logic [5:0] tens_x10;
  logic [5:0] ones;

  // tens digit
  always_comb begin
    priority if (value_i >= 6'd60) begin
      tens = 3'd6;
    end else if (value_i >= 6'd50) begin
      tens = 3'd5;
    end else if (value_i >= 6'd40) begin
      tens = 3'd4;
    end else if (value_i >= 6'd30) begin
      tens = 3'd3;
    end else if (value_i >= 6'd20) begin
      tens = 3'd2;
    end else if (value_i >= 6'd10) begin
      tens = 3'd1;
    end else begin
      tens = 3'd0;
    end
  end

  // ones digit = value - 10 * tens
  assign tens_x10 = 6'({tens, 3'b000}) + 6'({tens, 1'b0});
  assign ones     = value_i - tens_x10;

  assign tens_o = smdt_pkg::AsciiZero + {3'b000, tens};
  assign ones_o = smdt_pkg::AsciiZero + ones;

endmodule

/* hdl/seconds_to_month_day_time_ascii_core.sv */
// ----------------------------------------------------------------------------
// seconds_to_month_day_time_ascii_core: elapsed seconds to ASCII date/time
// Six-stage pipeline: seconds -> minutes -> hours -> days -> month -> ASCII.
// ----------------------------------------------------------------------------
// Converts an elapsed-seconds count (two non-leap years at most) into a
// three-letter month name, a two-digit day of month and hh:mm:ss, every
// digit as an ASCII code. One transaction is accepted per clock cycle while
// the output is not stalled, and its result passes through the six stage
// registers (three divide-by-constant multiplies, the day-of-year wrap, the
// month table search and the ASCII digit split). Stall on the output holds
// the pipeline in place and is passed back to the input only where a stage
// is full. Counts past two years still convert: the day of year wraps once
// by 365, and if it is still beyond the year the month letters are zero.
// ----------------------------------------------------------------------------
module seconds_to_month_day_time_ascii_core (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input channel
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [25:0] elapsed_seconds_i,
  // output channel
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [6:0]  month_letter_first_o,
  output logic [6:0]  month_letter_second_o,
  output logic [6:0]  month_letter_third_o,
  output logic [5:0]  day_tens_digit_o,
  output logic [5:0]  day_ones_digit_o,
  output logic [5:0]  hour_tens_digit_o,
  output logic [5:0]  hour_ones_digit_o,
  output logic [5:0]  minute_tens_digit_o,
  output logic [5:0]  minute_ones_digit_o,
  output logic [5:0]  second_tens_digit_o,
  output logic [5:0]  second_ones_digit_o
);

  localparam int unsigned NumStages = 6;

  // stage payloads
  typedef struct packed {
    logic [5:0]  t_low;   // count mod 64
    logic [20:0] tmin;    // count / 60
  } s1_t;

  typedef struct packed {
    logic [5:0]  sec;
    logic [5:0]  tmin_low;
    logic [14:0] thour;   // count / 3600
  } s2_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] thour_low;
    logic [9:0] days;     // whole days
  } s3_t;

  typedef struct packed {
    logic [5:0] sec;
    logic [5:0] min;
    logic [4:0] hour;
    logic [8:0] doy;      // day of year after the wrap
  } s4_t;

  typedef struct packed {
    logic [5:0]     sec;
    logic [5:0]     min;
    logic [4:0]     hour;
    smdt_pkg::cal_t cal;
  } s5_t;

  typedef struct packed {
    logic [20:0] letters;
    logic [5:0]  day_tens;
    logic [5:0]  day_ones;
    logic [5:0]  hour_tens;
    logic [5:0]  hour_ones;
    logic [5:0]  min_tens;
    logic [5:0]  min_ones;
    logic [5:0]  sec_tens;
    logic [5:0]  sec_ones;
  } s6_t;

  // low six bits of x * 60
  function automatic logic [5:0] mul60_low(input logic [5:0] x);
    logic [11:0] prod;
    prod = 12'({x, 6'b000000}) - 12'({x, 2'b00});
    return prod[5:0];
  endfunction

  logic [NumStages:0] vld;
  logic [NumStages:0] stl;

  s1_t s1_d, s1_q;
  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;
  s5_t s5_d, s5_q;
  s6_t s6_d, s6_q;

  logic [48:0] prod1;
  logic [39:0] prod2;
  logic [24:0] prod3;
  logic [8:0]  days_x24;
  logic [10:0] doy_raw;
  logic [10:0] doy_wrap;

  assign vld[0]      = in_valid_i;
  assign in_stall_o  = stl[0];
  assign stl[NumStages] = out_stall_i;
  assign out_valid_o = vld[NumStages];

  // stage 1: minutes = count / 60 = (count / 4) / 15
  assign prod1      = 49'(elapsed_seconds_i[25:2]) * 49'(smdt_pkg::Recip15Wide);
  assign s1_d.t_low = elapsed_seconds_i[5:0];
  assign s1_d.tmin  = prod1[smdt_pkg::Recip15WideShift +: 21];

  smdt_pipe_reg #(.Width($bits(s1_t))) u_stage1 (
    .clk_i, .rst_ni,
    .valid_i(vld[0]), .stall_o(stl[0]), .data_i(s1_d),
    .valid_o(vld[1]), .stall_i(stl[1]), .data_o(s1_q)
  );

  // stage 2: seconds, and hours = minutes / 60
  assign prod2         = 40'(s1_q.tmin[20:2]) * 40'(smdt_pkg::Recip15Narrow);
  assign s2_d.sec      = s1_q.t_low - mul60_low(s1_q.tmin[5:0]);
  assign s2_d.tmin_low = s1_q.tmin[5:0];
  assign s2_d.thour    = prod2[smdt_pkg::Recip15NarrowShift +: 15];

  smdt_pipe_reg #(.Width($bits(s2_t))) u_stage2 (
    .clk_i, .rst_ni,
    .valid_i(vld[1]), .stall_o(stl[1]), .data_i(s2_d),
    .valid_o(vld[2]), .stall_i(stl[2]), .data_o(s2_q)
  );

  // stage 3: minutes of the hour, and days = hours / 24 = (hours / 8) / 3
  assign prod3          = 25'(s2_q.thour[14:3]) * 25'(smdt_pkg::Recip3);
  assign s3_d.sec       = s2_q.sec;
  assign s3_d.min       = s2_q.tmin_low - mul60_low(s2_q.thour[5:0]);
  assign s3_d.thour_low = s2_q.thour[4:0];
  assign s3_d.days      = prod3[smdt_pkg::Recip3Shift +: 10];

  smdt_pipe_reg #(.Width($bits(s3_t))) u_stage3 (
    .clk_i, .rst_ni,
    .valid_i(vld[2]), .stall_o(stl[2]), .data_i(s3_d),
    .valid_o(vld[3]), .stall_i(stl[3]), .data_o(s3_q)
  );

  // stage 4: hour of day, day of year with a single wrap
  assign days_x24  = 9'({s3_q.days[4:0], 4'b0000}) + 9'({s3_q.days[4:0], 3'b000});
  assign doy_raw   = 11'(s3_q.days) + 11'd1;
  assign doy_wrap  = (doy_raw > 11'(smdt_pkg::DaysPerYear))
                     ? doy_raw - 11'(smdt_pkg::DaysPerYear) : doy_raw;
  assign s4_d.sec  = s3_q.sec;
  assign s4_d.min  = s3_q.min;
  assign s4_d.hour = s3_q.thour_low - days_x24[4:0];
  assign s4_d.doy  = doy_wrap[8:0];

  smdt_pipe_reg #(.Width($bits(s4_t))) u_stage4 (
    .clk_i, .rst_ni,
    .valid_i(vld[3]), .stall_o(stl[3]), .data_i(s4_d),
    .valid_o(vld[4]), .stall_i(stl[4]), .data_o(s4_q)
  );

  // stage 5: month table search
  smdt_calendar u_calendar (
    .doy_i(s4_q.doy),
    .cal_o(s5_d.cal)
  );

  assign s5_d.sec  = s4_q.sec;
  assign s5_d.min  = s4_q.min;
  assign s5_d.hour = s4_q.hour;

  smdt_pipe_reg #(.Width($bits(s5_t))) u_stage5 (
    .clk_i, .rst_ni,
    .valid_i(vld[4]), .stall_o(stl[4]), .data_i(s5_d),
    .valid_o(vld[5]), .stall_i(stl[5]), .data_o(s5_q)
  );

  // stage 6: ASCII digits
  smdt_ascii_digits u_day_digits (
    .value_i(s5_q.cal.dom), .tens_o(s6_d.day_tens), .ones_o(s6_d.day_ones)
  );

  smdt_ascii_digits u_hour_digits (
    .value_i({1'b0, s5_q.hour}), .tens_o(s6_d.hour_tens), .ones_o(s6_d.hour_ones)
  );

  smdt_ascii_digits u_min_digits (
    .value_i(s5_q.min), .tens_o(s6_d.min_tens), .ones_o(s6_d.min_ones)
  );

  smdt_ascii_digits u_sec_digits (
    .value_i(s5_q.sec), .tens_o(s6_d.sec_tens), .ones_o(s6_d.sec_ones)
  );

  assign s6_d.letters = s5_q.cal.letters;

  smdt_pipe_reg #(.Width($bits(s6_t))) u_stage6 (
    .clk_i, .rst_ni,
    .valid_i(vld[5]), .stall_o(stl[5]), .data_i(s6_d),
    .valid_o(vld[6]), .stall_i(stl[6]), .data_o(s6_q)
  );

  // output fields
  assign month_letter_first_o  = s6_q.letters[20:14];
  assign month_letter_second_o = s6_q.letters[13:7];
  assign month_letter_third_o  = s6_q.letters[6:0];
  assign day_tens_digit_o      = s6_q.day_tens;
  assign day_ones_digit_o      = s6_q.day_ones;
  assign hour_tens_digit_o     = s6_q.hour_tens;
  assign hour_ones_digit_o     = s6_q.hour_ones;
  assign minute_tens_digit_o   = s6_q.min_tens;
  assign minute_ones_digit_o   = s6_q.min_ones;
  assign second_tens_digit_o   = s6_q.sec_tens;
  assign second_ones_digit_o   = s6_q.sec_ones;

endmodule
